// ----- design/aabb_pkg.sv -----
// ============================================================================
// aabb_pkg
// Shared types and constants for the box pair overlap finder: command and
// status bundles between controller and datapath, and output field sizes.
// ============================================================================
package aabb_pkg;

    // Input command codes (tuser on the input stream)
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Reported slot number width (slots wrap modulo 32)
    localparam int SLOT_W     = 5;
    // Output tdata: older_slot, newer_slot, padded to a whole byte count
    localparam int OUT_DATA_W = 16;
    // Output tuser: hit, overflow
    localparam int OUT_USER_W = 2;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;    // empty the box store
        logic start;  // latch new box, restart the scan
        logic scan;   // run the compare pipeline this cycle
        logic fin;    // emit final result, commit box
    } aabb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;       // store holds MAX_BOXES boxes
        logic scan_done;  // all stored boxes compared
        logic out_free;   // output register can take an item
    } aabb_sts_t;

endpackage

// ----- design/aabb_ctrl.sv -----
// ============================================================================
// aabb_ctrl
// Controller for the overlap finder: accepts commands, sequences the scan
// over the box store and the final result of each add.
// ============================================================================
module aabb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    output logic                 s_tready,
    input  aabb_pkg::aabb_sts_t  sts,
    output aabb_pkg::aabb_cmd_t  cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == aabb_pkg::CMD_CLEAR)
                    begin
                        cmd.clr = 1'b1;
                    end
                    else if (sts.full)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/aabb_dp.sv -----
// ============================================================================
// aabb_dp
// Datapath for the overlap finder: box store memory, slot counter, a
// two-stage read/compare pipeline, one held hit and the output register.
// ============================================================================
module aabb_dp
#(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  aabb_pkg::aabb_cmd_t              cmd,
    input  logic [4*COORD_BITS-1:0]          box_in,
    input  logic                             m_tready,
    output aabb_pkg::aabb_sts_t              sts,
    output logic                             out_vld,
    output logic                             out_hit,
    output logic [aabb_pkg::SLOT_W-1:0]      out_older,
    output logic [aabb_pkg::SLOT_W-1:0]      out_newer,
    output logic                             out_ovf,
    output logic                             out_last
);

    localparam int BOX_W = 4 * COORD_BITS;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

    // Box store, fields from the low bits: min_x, min_y, max_x, max_y
    logic [BOX_W-1:0] mem [MAX_BOXES];

    logic [CNT_W-1:0] cnt_reg;
    logic [BOX_W-1:0] nb_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [BOX_W-1:0] rd_data_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             pend_vld_reg;
    logic [IDX_W-1:0] pend_idx_reg;

    logic                          out_vld_reg;
    logic                          out_hit_reg;
    logic [aabb_pkg::SLOT_W-1:0]   out_older_reg;
    logic [aabb_pkg::SLOT_W-1:0]   out_newer_reg;
    logic                          out_ovf_reg;
    logic                          out_last_reg;

    logic signed [COORD_BITS-1:0] a_lx, a_ly, a_hx, a_hy;
    logic signed [COORD_BITS-1:0] b_lx, b_ly, b_hx, b_hy;

    logic full;
    logic issue_done;
    logic out_free;
    logic overlap;
    logic hit;
    logic stall;
    logic adv;
    logic issue;
    logic push_scan;
    logic [aabb_pkg::SLOT_W-1:0] new_slot;

    // Coordinate unpacking: stored box (a) and new box (b)
    assign a_lx = $signed(rd_data_reg[0*COORD_BITS +: COORD_BITS]);
    assign a_ly = $signed(rd_data_reg[1*COORD_BITS +: COORD_BITS]);
    assign a_hx = $signed(rd_data_reg[2*COORD_BITS +: COORD_BITS]);
    assign a_hy = $signed(rd_data_reg[3*COORD_BITS +: COORD_BITS]);
    assign b_lx = $signed(nb_reg[0*COORD_BITS +: COORD_BITS]);
    assign b_ly = $signed(nb_reg[1*COORD_BITS +: COORD_BITS]);
    assign b_hx = $signed(nb_reg[2*COORD_BITS +: COORD_BITS]);
    assign b_hy = $signed(nb_reg[3*COORD_BITS +: COORD_BITS]);

    // Strict overlap: touching edges do not count
    assign overlap = (a_hx > b_lx) && (a_hy > b_ly) && (b_hx > a_lx) && (b_hy > a_ly);

    // Pipeline control
    assign full       = (cnt_reg == CNT_MAX);
    assign issue_done = (rd_idx_reg == cnt_reg);
    assign out_free   = !out_vld_reg || m_tready;
    assign hit        = cmp_vld_reg && overlap;
    assign stall      = hit && pend_vld_reg && !out_free;
    assign adv        = cmd.scan && !stall;
    assign issue      = adv && !issue_done;
    assign push_scan  = adv && hit && pend_vld_reg;
    assign new_slot   = aabb_pkg::SLOT_W'(cnt_reg);

    assign sts.full      = full;
    assign sts.scan_done = !cmp_vld_reg && issue_done;
    assign sts.out_free  = out_free;

    // Box store write on commit, registered read on issue
    always_ff @(posedge clk)
    begin
        if (cmd.fin && !full)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= nb_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (cmd.start)
        begin
            nb_reg <= box_in;
        end
        if (adv && hit)
        begin
            pend_idx_reg <= cmp_idx_reg;
        end
    end

    // Slot count and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.fin && !full)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.start)
            begin
                rd_idx_reg   <= '0;
                cmp_vld_reg  <= 1'b0;
                pend_vld_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (adv)
                begin
                    cmp_vld_reg <= issue;
                end
                if (adv && hit)
                begin
                    pend_vld_reg <= 1'b1;
                end
                else if (cmd.fin)
                begin
                    pend_vld_reg <= 1'b0;
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (push_scan || cmd.fin)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (push_scan)
        begin
            // earlier hit leaves once a later one is known
            out_hit_reg   <= 1'b1;
            out_older_reg <= aabb_pkg::SLOT_W'(pend_idx_reg);
            out_newer_reg <= new_slot;
            out_ovf_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_last_reg <= 1'b1;
            if (full)
            begin
                out_hit_reg   <= 1'b0;
                out_older_reg <= '0;
                out_newer_reg <= '0;
                out_ovf_reg   <= 1'b1;
            end
            else if (pend_vld_reg)
            begin
                out_hit_reg   <= 1'b1;
                out_older_reg <= aabb_pkg::SLOT_W'(pend_idx_reg);
                out_newer_reg <= new_slot;
                out_ovf_reg   <= 1'b0;
            end
            else
            begin
                out_hit_reg   <= 1'b0;
                out_older_reg <= '0;
                out_newer_reg <= new_slot;
                out_ovf_reg   <= 1'b0;
            end
        end
    end

    assign out_vld   = out_vld_reg;
    assign out_hit   = out_hit_reg;
    assign out_older = out_older_reg;
    assign out_newer = out_newer_reg;
    assign out_ovf   = out_ovf_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- design/aabb_pair_overlap_finder.sv -----
// ============================================================================
// aabb_pair_overlap_finder
// Each add scans the stored boxes with one store read per cycle while the output
// does not stall, and registers its final result once the scan ends; earlier
// pairs leave as soon as the next hit is found. A new item is taken only after
// the last one is through: a clear, an add to a full store, or an add with its
// scan and final result. Output stalls hold the scan.
// Reset empties the store.
// ============================================================================
module aabb_pair_overlap_finder
#(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // min_x, min_y, max_x, max_y (signed), zero padded to whole bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // cmd
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // older_slot [4:0], newer_slot [9:5], zero padded
    output logic [aabb_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // hit [0], overflow [1]
    output logic [aabb_pkg::OUT_USER_W-1:0]        m_axis_tuser,
    output logic                                   m_axis_tlast
);

    localparam int BOX_W = 4 * COORD_BITS;

    aabb_pkg::aabb_cmd_t          cmd;
    aabb_pkg::aabb_sts_t          sts;
    logic                         out_hit;
    logic [aabb_pkg::SLOT_W-1:0]  out_older;
    logic [aabb_pkg::SLOT_W-1:0]  out_newer;
    logic                         out_ovf;

    // Sequencer
    aabb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tuser  (s_axis_tuser),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store, compare pipeline and output register
    aabb_dp
    #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .box_in    (s_axis_tdata[BOX_W-1:0]),
        .m_tready  (m_axis_tready),
        .sts       (sts),
        .out_vld   (m_axis_tvalid),
        .out_hit   (out_hit),
        .out_older (out_older),
        .out_newer (out_newer),
        .out_ovf   (out_ovf),
        .out_last  (m_axis_tlast)
    );

    // Output packing
    assign m_axis_tdata = {{(aabb_pkg::OUT_DATA_W - 2*aabb_pkg::SLOT_W){1'b0}},
                           out_newer, out_older};
    assign m_axis_tuser = {out_ovf, out_hit};

endmodule

// ----- bench/tb_aabb_pair_overlap_finder.sv -----
// ============================================================================
// tb_aabb_pair_overlap_finder
// Self-checking bench for the box pair overlap finder. A queue of frames
// (clear, then a run of box adds) feeds a clocked driver. The driver keeps
// its own copy of the box store and predicts every pair report at input
// acceptance. A clocked monitor checks each output item against the oldest
// predicted report. Both sides idle in random bursts; the output side also
// holds off once for a long stretch so that the block backs up.
// ============================================================================
`timescale 1ns / 1ps

module tb_aabb_pair_overlap_finder;

    localparam int NUM_SLOTS   = 32;
    localparam int COORD_W     = 16;
    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 5;
    localparam int RANDOM_ITEMS = 320;
    localparam int TAIL_CYCLES = 60;    // beyond a full scan of the store
    localparam int QUIET_ITEMS = 40;    // last items run without idling
    localparam int LONG_HOLD   = 250;

    // One box, laid out as on the input tdata (min_x in the lowest bits)
    typedef struct packed {
        logic [COORD_W-1:0] max_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] min_x;
    } box_t;

    // One input item plus a flag that holds it back until all reports are in
    typedef struct packed {
        logic drain;
        logic cmd;
        box_t box;
    } box_item_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] older_slot;
        logic [4:0] newer_slot;
        logic       overflow;
        logic       last;
    } pair_report_t;

    // DUT ports
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [4*COORD_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = aabb_pkg::CMD_CLEAR;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [aabb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [aabb_pkg::OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    // Stimulus and prediction state
    box_item_t    pending_q[$];
    pair_report_t pair_q[$];
    box_t         frame_boxes[NUM_SLOTS];
    int unsigned  frame_count = 0;
    box_item_t    cur_item;
    bit           offering;
    bit           quiet_tail = 1'b0;
    int unsigned  idle_pct = 15;
    int unsigned  send_gap = 0;
    int unsigned  accepted_items = 0;

    // Monitor state
    int unsigned  seen_results = 0;
    int unsigned  stall_left = 0;
    int unsigned  hold_left = 0;
    bit           hold_done = 1'b0;
    int unsigned  mismatch_count = 0;
    pair_report_t want;

    aabb_pair_overlap_finder
    #(
        .MAX_BOXES  (NUM_SLOTS),
        .COORD_BITS (COORD_W)
    )
    dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF) clk = ~clk;

    // Strict overlap: touching edges do not count
    function automatic bit boxes_cross(box_t a, box_t b);
        return ($signed(a.max_x) > $signed(b.min_x)) && ($signed(a.max_y) > $signed(b.min_y))
            && ($signed(b.max_x) > $signed(a.min_x)) && ($signed(b.max_y) > $signed(a.min_y));
    endfunction

    // Append one expected report
    function automatic void post_report(pair_report_t rep);
        pair_q = {pair_q, rep};
    endfunction

    // Update the store copy and queue the reports this item causes
    function automatic void predict_overlaps(box_item_t it);
        pair_report_t rep;
        bit [NUM_SLOTS-1:0] hits;
        int last_i;
        int slot;
        hits   = '0;
        last_i = -1;
        if (it.cmd == aabb_pkg::CMD_CLEAR)
        begin
            frame_count = 0;
            return;
        end
        if (frame_count >= NUM_SLOTS)
        begin
            rep = '{1'b0, 5'd0, 5'd0, 1'b1, 1'b1};
            post_report(rep);
            return;
        end
        slot = frame_count;
        for (int i = 0; i < slot; i++)
        begin
            if (boxes_cross(frame_boxes[i], it.box))
            begin
                hits[i] = 1'b1;
                last_i  = i;
            end
        end
        for (int i = 0; i < slot; i++)
        begin
            if (hits[i])
            begin
                rep = '{1'b1, 5'(i), 5'(slot), 1'b0, (i == last_i)};
                post_report(rep);
            end
        end
        frame_boxes[slot] = it.box;
        frame_count = frame_count + 1;
        if (last_i < 0)
        begin
            rep = '{1'b0, 5'd0, 5'(slot), 1'b0, 1'b1};
            post_report(rep);
        end
    endfunction

    function automatic box_t box_of(int lx, int ly, int hx, int hy);
        box_t b;
        b.min_x = 16'(lx);
        b.min_y = 16'(ly);
        b.max_x = 16'(hx);
        b.max_y = 16'(hy);
        return b;
    endfunction

    function automatic logic [COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Random box: mostly small boxes on a coarse grid so that overlaps and
    // touching edges are common; also full-range, inverted and extreme boxes
    function automatic box_t make_box(int unsigned mode);
        box_t b;
        int x;
        int y;
        int w;
        int h;
        x = $urandom_range(0, 16) * 4 - 32;
        y = $urandom_range(0, 16) * 4 - 32;
        w = $urandom_range(0, 6) * 4;
        h = $urandom_range(0, 6) * 4;
        if (mode < 70)
        begin
            b = box_of(x, y, x + w, y + h);
        end
        else if (mode < 85)
        begin
            b = {$urandom(), $urandom()};
        end
        else if (mode < 95)
        begin
            b = box_of(x + w + 4, y + h + 4, x, y);
        end
        else
        begin
            b.min_x = extreme_coord();
            b.min_y = extreme_coord();
            b.max_x = extreme_coord();
            b.max_y = extreme_coord();
        end
        return b;
    endfunction

    function automatic void queue_item(logic cmd, box_t b, logic drain);
        box_item_t it;
        it.drain = drain;
        it.cmd   = cmd;
        it.box   = b;
        pending_q = {pending_q, it};
    endfunction

    // Driver: offers the next pending item, predicts at acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_overlaps(cur_item);
                offering = 1'b0;
                accepted_items = accepted_items + 1;
                if (accepted_items % 40 == 0)
                    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                if (!quiet_tail && $urandom_range(0, 99) < idle_pct)
                    send_gap = $urandom_range(1, 15);
            end
            quiet_tail = (pending_q.size() < QUIET_ITEMS);
            if (!offering)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_q.size() != 0 && !(pending_q[0].drain && pair_q.size() != 0))
                begin
                    cur_item = pending_q.pop_front();
                    s_axis_tdata  <= cur_item.box;
                    s_axis_tuser  <= cur_item.cmd;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output item, drives tready with stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_results = seen_results + 1;
                if (pair_q.size() == 0)
                begin
                    $error("unexpected item: hit %0d older %0d newer %0d overflow %0d",
                           m_axis_tuser[0], m_axis_tdata[4:0], m_axis_tdata[9:5],
                           m_axis_tuser[1]);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = pair_q.pop_front();
                    if (m_axis_tuser[0] !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, m_axis_tuser[0]);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_axis_tdata[4:0] !== want.older_slot)
                    begin
                        $error("older_slot: expected %0d, actual %0d",
                               want.older_slot, m_axis_tdata[4:0]);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_axis_tdata[9:5] !== want.newer_slot)
                    begin
                        $error("newer_slot: expected %0d, actual %0d",
                               want.newer_slot, m_axis_tdata[9:5]);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_axis_tuser[1] !== want.overflow)
                    begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, m_axis_tuser[1]);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, m_axis_tlast);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            // one long hold-off while the sender keeps offering
            if (!hold_done && seen_results >= 40)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int frames;
        int adds;
        bit big;
        frames = 0;

        // directed part
        queue_item(aabb_pkg::CMD_CLEAR, box_of(0, 0, 0, 0), 1'b1);
        queue_item(aabb_pkg::CMD_ADD, box_of(0, 0, 16, 16), 1'b0);
        queue_item(aabb_pkg::CMD_ADD, box_of(8, 8, 24, 24), 1'b0);
        queue_item(aabb_pkg::CMD_ADD, box_of(16, 0, 32, 16), 1'b0);     // touches first on x
        queue_item(aabb_pkg::CMD_ADD, box_of(0, 16, 8, 32), 1'b0);      // touches first on y
        queue_item(aabb_pkg::CMD_ADD, box_of(40, 40, -40, -40), 1'b0);  // inverted
        queue_item(aabb_pkg::CMD_ADD, box_of(-32768, -32768, 32767, 32767), 1'b0);
        queue_item(aabb_pkg::CMD_ADD, box_of(5, 5, 5, 5), 1'b0);        // zero size
        queue_item(aabb_pkg::CMD_ADD, box_of(32767, 32767, 32767, 32767), 1'b0);
        queue_item(aabb_pkg::CMD_ADD, box_of(-32768, -32768, -32768, -32768), 1'b0);
        queue_item(aabb_pkg::CMD_ADD, box_of(-32768, -32768, -32767, -32767), 1'b0);
        queue_item(aabb_pkg::CMD_CLEAR, box_of(-1, -1, -1, -1), 1'b1);  // data ignored
        queue_item(aabb_pkg::CMD_ADD, box_of(-32768, -32768, 32767, 32767), 1'b0);
        queue_item(aabb_pkg::CMD_ADD, box_of(-32768, -32768, 32767, 32767), 1'b0);
        queue_item(aabb_pkg::CMD_ADD, box_of(32766, -32768, 32767, 32767), 1'b0);
        queue_item(aabb_pkg::CMD_CLEAR, box_of(0, 0, 0, 0), 1'b0);
        queue_item(aabb_pkg::CMD_CLEAR, box_of(0, 0, 0, 0), 1'b0);      // clear of empty store

        // random frames; the first is large, with 31 to 35 adds, and may overflow the store
        while (pending_q.size() < RANDOM_ITEMS)
        begin
            frames = frames + 1;
            big  = (frames == 1) || ($urandom_range(0, 99) < 12);
            adds = big ? $urandom_range(31, 35) : $urandom_range(1, 12);
            queue_item(aabb_pkg::CMD_CLEAR, make_box($urandom_range(0, 99)),
                       ($urandom_range(0, 3) == 0));
            for (int k = 0; k < adds; k++)
            begin
                if (!big && $urandom_range(0, 99) < 4)
                    queue_item(aabb_pkg::CMD_CLEAR, make_box($urandom_range(0, 99)), 1'b0);
                queue_item(aabb_pkg::CMD_ADD, make_box($urandom_range(0, 99)), 1'b0);
            end
        end

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_q.size() != 0 || s_axis_tvalid || pair_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
